[sv/lcw_pkg.sv]
// Shared types, widths and constants of the line clip window core.
// No dependencies; compiled first.
`default_nettype none

package lcw_pkg;

  localparam int CoordBits = 12;
  localparam int PW        = CoordBits + 2;
  localparam int NW        = 2 * PW + 1;
  localparam int DW        = CoordBits + 1;
  localparam int QB        = CoordBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [PW-1:0]        wide_t;
  typedef logic signed [NW-1:0]        num_t;
  typedef logic [DW-1:0]               den_t;

  typedef enum logic [1:0] {
    REG_LEFT,
    REG_RIGHT,
    REG_BOTTOM,
    REG_TOP
  } cfg_idx_e;

  localparam coord_t WinLeftRst   = coord_t'(150);
  localparam coord_t WinRightRst  = coord_t'(450);
  localparam coord_t WinBottomRst = coord_t'(150);
  localparam coord_t WinTopRst    = coord_t'(300);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } clip_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
  } win_t;

  typedef struct packed {
    wide_t n;
    wide_t d;
  } frac_t;

  typedef struct packed {
    frac_t en;
    frac_t lv;
    wide_t delta;
    logic  rej;
  } axis_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    wide_t  dx;
    wide_t  dy;
    frac_t  enx;
    frac_t  lvx;
    frac_t  eny;
    frac_t  lvy;
    logic   rej;
  } sta_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    wide_t  dx;
    wide_t  dy;
    frac_t  tmin;
    frac_t  tmax;
    logic   rej;
  } bnd_t;

  typedef struct packed {
    logic vis;
    num_t sx;
    num_t sy;
    num_t ex;
    num_t ey;
    den_t dmin;
    den_t dmax;
  } div_in_t;

endpackage

`default_nettype wire

[sv/lcw_axis.sv]
// Per-axis edge tests: entering ratio clamped below at 0, leaving ratio clamped above at 1.
// Depends on lcw_pkg.
`default_nettype none

module lcw_axis (
  input  wire logic          clk_i,
  input  lcw_pkg::seg_t      seg_i,
  input  lcw_pkg::win_t      win_i,
  output lcw_pkg::sta_t      st_o
);
  import lcw_pkg::*;

  function automatic axis_t axis_fn(coord_t a1, coord_t a2, coord_t lo, coord_t hi);
    wide_t dd;
    wide_t d;
    wide_t e;
    wide_t l;
    axis_t r;
    dd    = wide_t'(a2) - wide_t'(a1);
    r.rej = 1'b0;
    if (dd > 0) begin
      d = dd;
      e = wide_t'(lo) - wide_t'(a1);
      l = wide_t'(hi) - wide_t'(a1);
    end else if (dd < 0) begin
      d = -dd;
      e = wide_t'(a1) - wide_t'(hi);
      l = wide_t'(a1) - wide_t'(lo);
    end else begin
      d     = wide_t'(1);
      e     = '0;
      l     = wide_t'(1);
      r.rej = (a1 < lo) || (a1 > hi);
    end
    if (e > 0) begin
      r.en.n = e;
      r.en.d = d;
    end else begin
      r.en.n = '0;
      r.en.d = wide_t'(1);
    end
    if (l < d) begin
      r.lv.n = l;
      r.lv.d = d;
    end else begin
      r.lv.n = wide_t'(1);
      r.lv.d = wide_t'(1);
    end
    r.delta = dd;
    return r;
  endfunction

  axis_t ax, ay;
  sta_t  st_d, st_q;

  assign ax = axis_fn(seg_i.start_x, seg_i.end_x, win_i.left, win_i.right);
  assign ay = axis_fn(seg_i.start_y, seg_i.end_y, win_i.bottom, win_i.top);

  always_comb begin
    st_d.x1  = seg_i.start_x;
    st_d.y1  = seg_i.start_y;
    st_d.dx  = ax.delta;
    st_d.dy  = ay.delta;
    st_d.enx = ax.en;
    st_d.lvx = ax.lv;
    st_d.eny = ay.en;
    st_d.lvy = ay.lv;
    st_d.rej = ax.rej | ay.rej;
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

`default_nettype wire

[sv/lcw_bound.sv]
// Merges axis ratios into tmin/tmax, then forms visibility and endpoint numerators.
// Depends on lcw_pkg.
`default_nettype none

module lcw_bound (
  input  wire logic          clk_i,
  input  lcw_pkg::sta_t      st_i,
  output lcw_pkg::div_in_t   div_o
);
  import lcw_pkg::*;

  logic signed [2*PW-1:0] en_y, en_x, lv_y, lv_x, cmp_a, cmp_b;
  bnd_t    bnd_d, bnd_q;
  div_in_t div_d, div_q;

  assign en_y = (2*PW)'(st_i.eny.n) * (2*PW)'(st_i.enx.d);
  assign en_x = (2*PW)'(st_i.enx.n) * (2*PW)'(st_i.eny.d);
  assign lv_y = (2*PW)'(st_i.lvy.n) * (2*PW)'(st_i.lvx.d);
  assign lv_x = (2*PW)'(st_i.lvx.n) * (2*PW)'(st_i.lvy.d);

  always_comb begin
    bnd_d.x1   = st_i.x1;
    bnd_d.y1   = st_i.y1;
    bnd_d.dx   = st_i.dx;
    bnd_d.dy   = st_i.dy;
    bnd_d.tmin = (en_y > en_x) ? st_i.eny : st_i.enx;
    bnd_d.tmax = (lv_y < lv_x) ? st_i.lvy : st_i.lvx;
    bnd_d.rej  = st_i.rej;
  end

  always_ff @(posedge clk_i) begin
    bnd_q <= bnd_d;
  end

  assign cmp_a = (2*PW)'(bnd_q.tmin.n) * (2*PW)'(bnd_q.tmax.d);
  assign cmp_b = (2*PW)'(bnd_q.tmax.n) * (2*PW)'(bnd_q.tmin.d);

  always_comb begin
    div_d.vis  = !bnd_q.rej && (cmp_a < cmp_b);
    div_d.sx   = num_t'(bnd_q.x1) * num_t'(bnd_q.tmin.d) +
                 num_t'(bnd_q.tmin.n) * num_t'(bnd_q.dx);
    div_d.sy   = num_t'(bnd_q.y1) * num_t'(bnd_q.tmin.d) +
                 num_t'(bnd_q.tmin.n) * num_t'(bnd_q.dy);
    div_d.ex   = num_t'(bnd_q.x1) * num_t'(bnd_q.tmax.d) +
                 num_t'(bnd_q.tmax.n) * num_t'(bnd_q.dx);
    div_d.ey   = num_t'(bnd_q.y1) * num_t'(bnd_q.tmax.d) +
                 num_t'(bnd_q.tmax.n) * num_t'(bnd_q.dy);
    div_d.dmin = bnd_q.tmin.d[DW-1:0];
    div_d.dmax = bnd_q.tmax.d[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

`default_nettype wire

[sv/lcw_div.sv]
// Pipelined restoring divider lane, one quotient bit per stage, floor or ceiling rounding.
// Depends on lcw_pkg.
`default_nettype none

module lcw_div (
  input  wire logic          clk_i,
  input  lcw_pkg::num_t      num_i,
  input  lcw_pkg::den_t      den_i,
  input  wire logic          ceil_i,
  output lcw_pkg::coord_t    quo_o
);
  import lcw_pkg::*;

  logic [NW-1:0] mag;
  logic [DW-1:0] rem_q  [QB+1];
  logic [QB-1:0] quo_q  [QB+1];
  logic          neg_q  [QB+1];
  logic          ceil_q [QB+1];
  logic [QB-1:0] low_q  [QB];
  logic [DW-1:0] den_q  [QB];

  assign mag = num_i[NW-1] ? NW'(-num_i) : num_i;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= mag[QB+DW-1:QB];
    low_q[0]  <= mag[QB-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    neg_q[0]  <= num_i[NW-1];
    ceil_q[0] <= ceil_i;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] trial, diff;
    assign trial = {rem_q[k], low_q[k][QB-1-k]};
    assign diff  = trial - {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      quo_q[k+1]  <= {quo_q[k][QB-2:0], !diff[DW]};
      neg_q[k+1]  <= neg_q[k];
      ceil_q[k+1] <= ceil_q[k];
    end
    if (k < QB - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        low_q[k+1] <= low_q[k];
        den_q[k+1] <= den_q[k];
      end
    end
  end

  logic          inc;
  logic [QB:0]   mag2, res;

  assign inc   = (|rem_q[QB]) & (ceil_q[QB] ^ neg_q[QB]);
  assign mag2  = {1'b0, quo_q[QB]} + (QB+1)'(inc);
  assign res   = neg_q[QB] ? -mag2 : mag2;
  assign quo_o = res[CoordBits-1:0];

endmodule

`default_nettype wire

[sv/line_clip_window_core.sv]
// Liang-Barsky line clipper against a configurable window; top level.
// Depends on lcw_pkg, lcw_axis, lcw_bound, lcw_div.
// A new segment is taken every cycle (busy_o stays low). Each result passes
// the axis register, two bound registers, the one-bit-per-stage divider
// lanes and the result register; results leave in order and must be
// taken in the cycle valid_o is high. The user must write window registers
// through the cfg port only while no segment is in flight; the core does not enforce it.
`default_nettype none

module line_clip_window_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  lcw_pkg::seg_t          seg_i,
  output logic                   busy_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  lcw_pkg::cfg_idx_e      cfg_index_i,
  input  lcw_pkg::coord_t        cfg_data_i,
  output logic                   valid_o,
  output lcw_pkg::clip_t         result_o
);
  import lcw_pkg::*;

  localparam int PipeLen = 4 + QB;
  localparam int OutLat  = PipeLen + 1;

  win_t    win_q;
  sta_t    sta;
  div_in_t dvi;
  coord_t  qsx, qsy, qex, qey;
  logic    vld_q [PipeLen];
  logic    vis_q [QB+1];
  logic    valid_q;
  clip_t   result_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.left   <= WinLeftRst;
      win_q.right  <= WinRightRst;
      win_q.bottom <= WinBottomRst;
      win_q.top    <= WinTopRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LEFT:   win_q.left   <= cfg_data_i;
        REG_RIGHT:  win_q.right  <= cfg_data_i;
        REG_BOTTOM: win_q.bottom <= cfg_data_i;
        REG_TOP:    win_q.top    <= cfg_data_i;
        default:    win_q        <= win_q;
      endcase
    end
  end

  lcw_axis u_axis (
    .clk_i (clk_i),
    .seg_i (seg_i),
    .win_i (win_q),
    .st_o  (sta)
  );

  lcw_bound u_bound (
    .clk_i (clk_i),
    .st_i  (sta),
    .div_o (dvi)
  );

  lcw_div u_div_sx (.clk_i(clk_i), .num_i(dvi.sx), .den_i(dvi.dmin), .ceil_i(1'b1), .quo_o(qsx));
  lcw_div u_div_sy (.clk_i(clk_i), .num_i(dvi.sy), .den_i(dvi.dmin), .ceil_i(1'b1), .quo_o(qsy));
  lcw_div u_div_ex (.clk_i(clk_i), .num_i(dvi.ex), .den_i(dvi.dmax), .ceil_i(1'b0), .quo_o(qex));
  lcw_div u_div_ey (.clk_i(clk_i), .num_i(dvi.ey), .den_i(dvi.dmax), .ceil_i(1'b0), .quo_o(qey));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PipeLen; i++) vld_q[i] <= 1'b0;
      valid_q  <= 1'b0;
      result_q <= '0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int i = 1; i < PipeLen; i++) vld_q[i] <= vld_q[i-1];
      valid_q                <= vld_q[PipeLen-1];
      result_q.visible       <= vld_q[PipeLen-1] && vis_q[QB];
      result_q.clip_start_x  <= vis_q[QB] ? qsx : '0;
      result_q.clip_start_y  <= vis_q[QB] ? qsy : '0;
      result_q.clip_end_x    <= vis_q[QB] ? qex : '0;
      result_q.clip_end_y    <= vis_q[QB] ? qey : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q[0] <= dvi.vis;
    for (int i = 1; i <= QB; i++) vis_q[i] <= vis_q[i-1];
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, OutLat))
    else $error("result without matching transaction");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !result_o.visible) |->
      (result_o.clip_start_x == '0 && result_o.clip_start_y == '0 &&
       result_o.clip_end_x == '0 && result_o.clip_end_y == '0))
    else $error("rejected segment carries nonzero coordinates");

  a_vis_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.visible |-> valid_o)
    else $error("visible flag outside result strobe");

endmodule

`default_nettype wire

[test/tb_line_clip_window_core.sv]
// Testbench for line_clip_window_core: directed and random segments, window reconfiguration,
// scoreboard against an exact-fraction Liang-Barsky predictor.
// Depends on lcw_pkg and the line_clip_window_core RTL.
`default_nettype none

module tb_line_clip_window_core;
  import lcw_pkg::*;

  typedef struct packed {
    seg_t  s;
    logic  chk;
    clip_t e;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  seg_t     seg_i = '0;
  logic     busy_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_e cfg_index_i = REG_LEFT;
  coord_t   cfg_data_i = '0;
  logic     valid_o;
  clip_t    result_o;

  win_t   cur_win;
  clip_t  clip_q[$];
  int     n_fail = 0;
  longint cyc = 0;

  line_clip_window_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .seg_i(seg_i), .busy_o(busy_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .valid_o(valid_o), .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint floor_q(longint a, longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  function automatic clip_t clip_predict(seg_t s, win_t w);
    longint x1, y1, dx, dy, n, d;
    longint p[4], q[4];
    longint nmin, dmin, nmax, dmax;
    logic   rej;
    clip_t  r;
    x1 = s.start_x; y1 = s.start_y;
    dx = longint'(s.end_x) - x1;
    dy = longint'(s.end_y) - y1;
    p[0] = -dx; q[0] = x1 - w.left;
    p[1] = dx;  q[1] = longint'(w.right) - x1;
    p[2] = -dy; q[2] = y1 - w.bottom;
    p[3] = dy;  q[3] = longint'(w.top) - y1;
    nmin = 0; dmin = 1; nmax = 1; dmax = 1; rej = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (p[i] < 0) begin
        n = -q[i]; d = -p[i];
        if (n * dmin > nmin * d) begin nmin = n; dmin = d; end
      end else if (p[i] > 0) begin
        n = q[i]; d = p[i];
        if (n * dmax < nmax * d) begin nmax = n; dmax = d; end
      end else if (q[i] < 0) begin
        rej = 1'b1;
      end
    end
    r = '0;
    if (!rej && nmin * dmax < nmax * dmin) begin
      r.visible      = 1'b1;
      r.clip_start_x = coord_t'(-floor_q(-(x1 * dmin + nmin * dx), dmin));
      r.clip_start_y = coord_t'(-floor_q(-(y1 * dmin + nmin * dy), dmin));
      r.clip_end_x   = coord_t'(floor_q(x1 * dmax + nmax * dx, dmax));
      r.clip_end_y   = coord_t'(floor_q(y1 * dmax + nmax * dy, dmax));
    end
    return r;
  endfunction

  function automatic seg_t mk_seg(int a, int b, int c, int d);
    return '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d)};
  endfunction

  function automatic clip_t mk_clip(logic v, int a, int b, int c, int d);
    return '{v, coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d)};
  endfunction

  // result check, sampled mid-cycle
  always @(negedge clk_i) begin
    clip_t e;
    if (rst_ni && valid_o) begin
      if (clip_q.size() == 0) begin
        $error("result with no transaction pending");
        n_fail++;
      end else begin
        e = clip_q.pop_front();
        if (result_o.visible !== e.visible) begin
          $error("visible exp %0d got %0d", e.visible, result_o.visible); n_fail++;
        end
        if (result_o.clip_start_x !== e.clip_start_x) begin
          $error("clip_start_x exp %0d got %0d", e.clip_start_x, result_o.clip_start_x);
          n_fail++;
        end
        if (result_o.clip_start_y !== e.clip_start_y) begin
          $error("clip_start_y exp %0d got %0d", e.clip_start_y, result_o.clip_start_y);
          n_fail++;
        end
        if (result_o.clip_end_x !== e.clip_end_x) begin
          $error("clip_end_x exp %0d got %0d", e.clip_end_x, result_o.clip_end_x); n_fail++;
        end
        if (result_o.clip_end_y !== e.clip_end_y) begin
          $error("clip_end_y exp %0d got %0d", e.clip_end_y, result_o.clip_end_y); n_fail++;
        end
      end
    end
  end

  // called and returns at a rising edge
  task automatic send_seg(seg_t s, int gap, logic chk, clip_t e);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    seg_i   <= s;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    clip_q.push_back(chk ? e : clip_predict(s, cur_win));
  endtask

  task automatic write_win(win_t w);
    cfg_idx_e idx;
    coord_t   v;
    start_i <= 1'b0;
    wait (clip_q.size() == 0);
    repeat (24) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        REG_LEFT:   v = w.left;
        REG_RIGHT:  v = w.right;
        REG_BOTTOM: v = w.bottom;
        default:    v = w.top;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= v;
      forever begin
        @(negedge clk_i);
        if (cfg_ready_o) break;
        @(posedge clk_i);
      end
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_win = w;
  endtask

  function automatic coord_t near_coord(coord_t lo, coord_t hi);
    return coord_t'(int'(lo) - 64 + int'($urandom_range(int'(hi) - int'(lo) + 128)));
  endfunction

  task automatic random_phase(int n, int idle_pct);
    seg_t s;
    int   gap;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 45) begin
        s = seg_t'($urandom());
        s.start_x = coord_t'($urandom()); s.end_y = coord_t'($urandom());
      end else begin
        s.start_x = near_coord(cur_win.left, cur_win.right);
        s.end_x   = near_coord(cur_win.left, cur_win.right);
        s.start_y = near_coord(cur_win.bottom, cur_win.top);
        s.end_y   = near_coord(cur_win.bottom, cur_win.top);
        if ($urandom_range(9) == 0) s.end_x = s.start_x;
        if ($urandom_range(9) == 0) s.end_y = s.start_y;
      end
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      send_seg(s, gap, 1'b0, '0);
    end
  endtask

  initial begin
    dir_row_t dir_tab[14];
    win_t     w;
    int       a, b;
    int       idle_mode[3];
    dir_tab[0]  = '{mk_seg(200, 200, 300, 250), 1, mk_clip(1, 200, 200, 300, 250)};
    dir_tab[1]  = '{mk_seg(-2048, -2048, -2048, 2047), 1, mk_clip(0, 0, 0, 0, 0)};
    dir_tab[2]  = '{mk_seg(2047, 2047, 2047, 2047), 1, mk_clip(0, 0, 0, 0, 0)};
    dir_tab[3]  = '{mk_seg(-2048, -2048, 2047, 2047), 0, '0};
    dir_tab[4]  = '{mk_seg(200, 200, 200, 200), 1, mk_clip(1, 200, 200, 200, 200)};
    dir_tab[5]  = '{mk_seg(150, 150, 150, 150), 1, mk_clip(1, 150, 150, 150, 150)};
    dir_tab[6]  = '{mk_seg(0, 200, 1000, 200), 1, mk_clip(1, 150, 200, 450, 200)};
    dir_tab[7]  = '{mk_seg(300, 0, 300, 2000), 1, mk_clip(1, 300, 150, 300, 300)};
    dir_tab[8]  = '{mk_seg(1000, 200, 0, 200), 1, mk_clip(1, 450, 200, 150, 200)};
    dir_tab[9]  = '{mk_seg(0, 300, 1000, 300), 1, mk_clip(1, 150, 300, 450, 300)};
    dir_tab[10] = '{mk_seg(100, 100, 150, 150), 1, mk_clip(0, 0, 0, 0, 0)};
    dir_tab[11] = '{mk_seg(2047, -2048, -2048, 2047), 0, '0};
    dir_tab[12] = '{mk_seg(140, 141, 461, 317), 0, '0};
    dir_tab[13] = '{mk_seg(449, 299, 151, 151), 0, '0};
    idle_mode = '{0, 66, 38};
    cur_win = '{WinLeftRst, WinRightRst, WinBottomRst, WinTopRst};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_seg(dir_tab[i].s, i % 3, dir_tab[i].chk, dir_tab[i].e);
    random_phase(80, 0);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: w = '{coord_t'(-2048), 12'sd2047, coord_t'(-2048), 12'sd2047};
        1: w = '{12'sd450, 12'sd150, 12'sd300, 12'sd150};
        2: w = '{12'sd5, 12'sd5, -12'sd7, -12'sd7};
        3: w = '{12'sd2047, 12'sd2047, coord_t'(-2048), coord_t'(-2048)};
        default: begin
          a = $urandom_range(4095) - 2048; b = $urandom_range(4095) - 2048;
          w.left = coord_t'(a < b ? a : b); w.right = coord_t'(a < b ? b : a);
          a = $urandom_range(4095) - 2048; b = $urandom_range(4095) - 2048;
          w.bottom = coord_t'(a < b ? a : b); w.top = coord_t'(a < b ? b : a);
        end
      endcase
      write_win(w);
      if (ph == 0) send_seg(mk_seg(-2048, -2048, 2047, 2047), 0, 1'b1,
                            mk_clip(1, -2048, -2048, 2047, 2047));
      random_phase(80, idle_mode[ph % 3]);
    end
    start_i <= 1'b0;

    wait (clip_q.size() == 0);
    repeat (30) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[line_clip_window_core.f]
sv/lcw_pkg.sv
sv/lcw_axis.sv
sv/lcw_bound.sv
sv/lcw_div.sv
sv/line_clip_window_core.sv
test/tb_line_clip_window_core.sv
